FILE: rtl/core/rrps_pkg.sv
// Shared types and codes for the round-robin process scheduler.
`default_nettype none
package rrps_pkg;

  // Field widths of the request and result items
  localparam int REQ_W    = 2;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int TID_W    = 4;
  localparam int TICKS_W  = 32;
  localparam int QUANT_W  = 16;

  // Task table size; every id fits in TID_W bits
  localparam int TASK_COUNT = 16;

  // Configuration port
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam logic [APB_AW-3:0] REG_QUANTUM = 1'b0;
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd100;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CREATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SLEEP  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOCUR  = 2'd2;

  // Task states
  localparam logic [1:0] TS_UNUSED   = 2'd0;
  localparam logic [1:0] TS_READY    = 2'd1;
  localparam logic [1:0] TS_RUNNING  = 2'd2;
  localparam logic [1:0] TS_SLEEPING = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] sleep_time;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    task_id;
    logic                switched;
    logic                current_valid;
    logic [TICKS_W-1:0]  ticks_used;
  } rsp_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/rrps_cfg.sv
// APB register block holding the time-slice quantum.
`default_nettype none
module rrps_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rrps_pkg::APB_AW-1:0] paddr,
  input  wire logic [rrps_pkg::APB_DW-1:0] pwdata,
  output logic      [rrps_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output logic      [rrps_pkg::QUANT_W-1:0] quantum
);
  import rrps_pkg::*;

  logic                 wr_en;
  logic [APB_AW-3:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (wr_en && (reg_idx == REG_QUANTUM)) begin
      quantum <= pwdata[QUANT_W-1:0];
    end
  end

  // Read-back
  always_comb begin
    if (reg_idx == REG_QUANTUM) begin
      prdata = {{(APB_DW-QUANT_W){1'b0}}, quantum};
    end else begin
      prdata = '0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rrps_sched.sv
// Task table, run queue and one-pass request logic of the scheduler.
`default_nettype none
module rrps_sched (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire rrps_pkg::req_item_t           req,
  input  wire logic [rrps_pkg::QUANT_W-1:0]  quantum,
  output rrps_pkg::rsp_item_t                rsp
);
  import rrps_pkg::*;

  localparam int IW = $clog2(TASK_COUNT);
  localparam int FW = $clog2(TASK_COUNT + 1);
  localparam logic [IW-1:0] LAST_ID = IW'(TASK_COUNT - 1);
  localparam logic [FW-1:0] FREE_END = FW'(TASK_COUNT);

  // Task table and rings
  logic [1:0]        task_state  [TASK_COUNT];
  logic [TIME_W-1:0] time_left   [TASK_COUNT];
  logic [TICKS_W-1:0] tick_total [TASK_COUNT];
  logic [IW-1:0]     run_ring    [TASK_COUNT];
  logic [IW-1:0]     run_head;
  logic [IW-1:0]     run_tail;
  logic [FW-1:0]     free_head;
  logic [IW-1:0]     current_task;
  logic              have_current;

  // Decisions for this item
  logic               q_empty;
  logic [IW-1:0]      head_id;
  logic [IW-1:0]      new_id;
  logic [TICKS_W-1:0] cur_ticks;
  logic [TICKS_W-1:0] cur_ticks_inc;
  logic [TIME_W-1:0]  cur_tl_dec;
  logic               start_en;
  logic [IW-1:0]      start_id;
  logic               start_self;
  logic               pop_en;
  logic               push_en;
  logic [IW-1:0]      push_id;
  logic               tt_we;
  logic               tl_we;
  logic [TIME_W-1:0]  tl_val;
  logic               st_we;
  logic [1:0]         st_val;
  logic               create_en;
  logic [STATUS_W-1:0] status;
  logic [IW-1:0]      cur_after;
  logic               have_after;
  logic [TICKS_W-1:0] ticks_after;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    return (p == LAST_ID) ? '0 : p + 1'b1;
  endfunction

  assign q_empty    = (run_head == run_tail);
  assign head_id    = run_ring[run_head];
  assign new_id     = free_head[IW-1:0];
  assign cur_ticks  = tick_total[current_task];
  assign cur_ticks_inc = (&cur_ticks) ? cur_ticks : cur_ticks + 1'b1;
  assign cur_tl_dec = time_left[current_task] - 1'b1;
  assign start_self = start_en && (start_id == current_task);

  // Request decode and scheduling rules
  always_comb begin
    start_en  = 1'b0;
    start_id  = '0;
    pop_en    = 1'b0;
    push_en   = 1'b0;
    push_id   = current_task;
    tt_we     = 1'b0;
    tl_we     = 1'b0;
    tl_val    = cur_tl_dec;
    st_we     = 1'b0;
    st_val    = TS_READY;
    create_en = 1'b0;
    status    = STAT_OK;
    case (req.req_type)
      REQ_TICK: begin
        if (!have_current) begin
          start_en = 1'b1;
        end else begin
          tt_we = 1'b1;
          if (current_task == '0) begin
            // idle task leaves only for a queued task
            if (!q_empty) begin
              start_en = 1'b1;
              start_id = head_id;
              pop_en   = 1'b1;
            end
          end else if (task_state[current_task] == TS_RUNNING) begin
            tl_we = 1'b1;
            if (cur_tl_dec == '0) begin
              // slice used up: requeue, then take the head (itself if alone)
              st_we    = 1'b1;
              push_en  = 1'b1;
              pop_en   = 1'b1;
              start_en = 1'b1;
              start_id = q_empty ? current_task : head_id;
            end
          end else begin
            // current task asleep: next queued task, else idle
            start_en = 1'b1;
            if (!q_empty) begin
              start_id = head_id;
              pop_en   = 1'b1;
            end
          end
        end
      end
      REQ_CREATE: begin
        if (free_head >= FREE_END) begin
          status = STAT_NOFREE;
        end else begin
          create_en = 1'b1;
          push_en   = 1'b1;
          push_id   = new_id;
        end
      end
      REQ_SLEEP: begin
        if (!have_current) begin
          status = STAT_NOCUR;
        end else begin
          tl_we  = 1'b1;
          tl_val = req.sleep_time;
          st_we  = 1'b1;
          st_val = TS_SLEEPING;
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields after the step
  always_comb begin
    cur_after  = start_en ? start_id : current_task;
    have_after = have_current || start_en;
    if (!have_after) begin
      ticks_after = '0;
    end else if (tt_we && (cur_after == current_task)) begin
      ticks_after = cur_ticks_inc;
    end else begin
      ticks_after = tick_total[cur_after];
    end
    rsp.status        = status;
    rsp.switched      = start_en;
    rsp.current_valid = have_after;
    rsp.ticks_used    = ticks_after;
    if (create_en) begin
      rsp.task_id = TID_W'(new_id);
    end else if (have_after) begin
      rsp.task_id = TID_W'(cur_after);
    end else begin
      rsp.task_id = '0;
    end
  end

  // Table, pointer and current-task update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        task_state[i]  <= TS_UNUSED;
        time_left[i]   <= '0;
        tick_total[i]  <= '0;
      end
      task_state[0] <= TS_READY;
      run_head      <= '0;
      run_tail      <= '0;
      free_head     <= FW'(1);
      current_task  <= '0;
      have_current  <= 1'b0;
    end else if (en) begin
      if (tt_we) begin
        tick_total[current_task] <= cur_ticks_inc;
      end
      // a task restarting itself takes only the start values below
      if (tl_we && !start_self) begin
        time_left[current_task] <= tl_val;
      end
      if (st_we && !start_self) begin
        task_state[current_task] <= st_val;
      end
      if (create_en) begin
        task_state[new_id] <= TS_READY;
        free_head          <= free_head + 1'b1;
      end
      if (push_en) begin
        run_tail <= wrap_inc(run_tail);
      end
      if (pop_en) begin
        run_head <= wrap_inc(run_head);
      end
      if (start_en) begin
        task_state[start_id] <= TS_RUNNING;
        time_left[start_id]  <= {{(TIME_W-QUANT_W){1'b0}}, quantum};
        current_task         <= start_id;
        have_current         <= 1'b1;
      end
    end
  end

  // Run-queue ring storage
  always_ff @(posedge clk) begin
    if (en && push_en) begin
      run_ring[run_tail] <= push_id;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/round_robin_process_scheduler_unit.sv
// Top level of the round-robin process scheduler: channels, staging registers.
//
//   channel   direction  handshake              payload
//   in        to block   in_valid / in_ready    in_data  (req_item_t)
//   out       from block out_valid / out_ready  out_data (rsp_item_t)
//   cfg       to block   APB psel/penable/pready quantum at byte address 0
//
// One item per cycle sustained while out_ready stays high; an accepted item
// passes through the input register, then through the task table logic into
// the result register, where out_valid rises with its result.
// Reset (rst, synchronous) leaves task 0 ready, no current task, quantum 100.
// A stalled result holds in the output register; the input register still
// takes one more item, and in_ready drops only when both are full.
`default_nettype none
module round_robin_process_scheduler_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire rrps_pkg::req_item_t          in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output rrps_pkg::rsp_item_t               out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rrps_pkg::APB_AW-1:0]  paddr,
  input  wire logic [rrps_pkg::APB_DW-1:0]  pwdata,
  output logic      [rrps_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);
  import rrps_pkg::*;

  logic               in_full;
  req_item_t          in_q;
  logic               advance;
  rsp_item_t          rsp;
  logic [QUANT_W-1:0] quantum;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= rsp;
    end
  end

  rrps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quantum (quantum)
  );

  rrps_sched u_sched (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .req     (in_q),
    .quantum (quantum),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire
